/* rtl/blg_pkg.sv */
package blg_pkg;

    localparam int MV_W   = 14;
    localparam int LVL_W  = 7;
    localparam int HYST_W = 8;
    localparam int SUM_W  = 22;

    localparam int ROM_SIZE      = 101;
    localparam int ADDR_W        = $clog2(ROM_SIZE);
    localparam int TABLE_ENTRIES = 101;
    localparam int SAMPLES_DEF   = 8;
    localparam int LVL_MAX       = 100;

    localparam int USED_ENTRIES = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
    localparam int TOP_RAW      = USED_ENTRIES - 1;
    localparam int TOP_IDX      = (TOP_RAW < 1) ? 1 : ((TOP_RAW > LVL_MAX) ? LVL_MAX : TOP_RAW);
    localparam logic [ADDR_W-1:0] TOP_LVL = ADDR_W'(TOP_IDX);

    localparam logic [HYST_W-1:0] HYST_RESET = 8'd10;

    // rounding of the position between two neighbouring thresholds
    localparam int RND_W = MV_W + 8;
    localparam logic [RND_W-1:0] ROUND_SCALE = RND_W'(100);
    localparam logic [RND_W-1:0] ROUND_HALF  = RND_W'(50);

    // 1% voltage thresholds in mV
    localparam logic [MV_W-1:0] VOLT_ROM [ROM_SIZE] = '{
        14'd3200, 14'd3250, 14'd3300, 14'd3350, 14'd3400,
        14'd3450, 14'd3500, 14'd3550, 14'd3600, 14'd3650,
        14'd3700, 14'd3703, 14'd3706, 14'd3710, 14'd3713,
        14'd3716, 14'd3719, 14'd3723, 14'd3726, 14'd3729,
        14'd3732, 14'd3735, 14'd3739, 14'd3742, 14'd3745,
        14'd3748, 14'd3752, 14'd3755, 14'd3758, 14'd3761,
        14'd3765, 14'd3768, 14'd3771, 14'd3774, 14'd3777,
        14'd3781, 14'd3784, 14'd3787, 14'd3790, 14'd3794,
        14'd3797, 14'd3800, 14'd3805, 14'd3811, 14'd3816,
        14'd3821, 14'd3826, 14'd3832, 14'd3837, 14'd3842,
        14'd3847, 14'd3853, 14'd3858, 14'd3863, 14'd3868,
        14'd3874, 14'd3879, 14'd3884, 14'd3889, 14'd3895,
        14'd3900, 14'd3906, 14'd3911, 14'd3917, 14'd3922,
        14'd3928, 14'd3933, 14'd3939, 14'd3944, 14'd3950,
        14'd3956, 14'd3961, 14'd3967, 14'd3972, 14'd3978,
        14'd3983, 14'd3989, 14'd3994, 14'd4000, 14'd4008,
        14'd4015, 14'd4023, 14'd4031, 14'd4038, 14'd4046,
        14'd4054, 14'd4062, 14'd4069, 14'd4077, 14'd4085,
        14'd4092, 14'd4100, 14'd4111, 14'd4122, 14'd4133,
        14'd4144, 14'd4156, 14'd4167, 14'd4178, 14'd4189,
        14'd4200
    };

    localparam logic [MV_W-1:0] ROM_LO_MV = VOLT_ROM[0];
    localparam logic [MV_W-1:0] ROM_HI_MV = VOLT_ROM[TOP_IDX];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_WALK_UP,
        ST_WALK_DN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/blg_if.sv */
interface blg_sample_if;
    import blg_pkg::*;

    logic            valid;
    logic            ready;
    logic [MV_W-1:0] sample_mv;

    modport source (output valid, output sample_mv, input ready);
    modport sink   (input valid, input sample_mv, output ready);
endinterface

interface blg_result_if;
    import blg_pkg::*;

    logic             valid;
    logic             ready;
    logic [MV_W-1:0]  average_mv;
    logic [LVL_W-1:0] level_pct;

    modport source (output valid, output average_mv, output level_pct, input ready);
    modport sink   (input valid, input average_mv, input level_pct, output ready);
endinterface

/* rtl/battery_level_gauge.sv */
// Battery charge gauge. Voltage samples (mV) are summed in groups of
// SAMPLES_PER_AVERAGE; each full group gives a truncated average, and when that
// average differs from the previous one a result carries the average and a
// charge level in percent. The level comes from a 1% threshold table held in a
// synchronous ROM, rounded to the nearer neighbouring entry, then moved one step
// at a time against the previous level with a margin of hysteresis_mv (written
// through i_cfg_wr_en / i_cfg_wr_data, reset value 10). The first result after
// reset takes the table level directly. A sample that does not close a group
// only adds to the sum. Closing a group runs the reciprocal-multiply divider,
// a scan of the table (one ROM read per cycle), the hysteresis walk (one ROM
// read per step) and a load of the output register; no sample is taken
// meanwhile. Results sit in an output register, so samples keep flowing while
// a result waits to be taken; a later result holds in its last step until
// that register is free.
module battery_level_gauge #(
    parameter int SAMPLES_PER_AVERAGE = blg_pkg::SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    blg_sample_if.sink                 i_sample,
    blg_result_if.source               o_result,
    input  logic                       i_cfg_wr_en,
    input  logic [blg_pkg::HYST_W-1:0] i_cfg_wr_data
);
    import blg_pkg::*;

    logic [HYST_W-1:0] r_hyst;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    logic [ADDR_W-1:0] w_rom_addr;
    logic [MV_W-1:0]   w_rom_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hyst <= HYST_RESET;
        end else if (i_cfg_wr_en) begin
            r_hyst <= i_cfg_wr_data;
        end
    end

    blg_ctrl #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_sample),
        .o_result   (o_result),
        .i_hyst_mv  (r_hyst),
        .o_div_req  (w_div_req),
        .i_div_rsp  (w_div_rsp),
        .o_rom_addr (w_rom_addr),
        .i_rom_data (w_rom_data)
    );

    blg_div #(
        .DIVISOR (SAMPLES_PER_AVERAGE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    blg_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    a_no_sample_during_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |-> !w_div_rsp.busy)
        else $error("sample transaction while divider busy");

    a_div_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> $past(w_div_rsp.busy))
        else $error("divider done without a division in progress");

    a_rom_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rom_addr <= TOP_LVL)
        else $error("table address beyond top entry");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.level_pct <= LVL_W'(LVL_MAX)))
        else $error("level above 100 percent");

endmodule

/* rtl/blg_rom.sv */
module blg_rom (
    input  logic                       i_clk,
    input  logic [blg_pkg::ADDR_W-1:0] i_addr,
    output logic [blg_pkg::MV_W-1:0]   o_data
);
    import blg_pkg::*;

    logic [MV_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_addr <= ADDR_W'(ROM_SIZE - 1)) begin
            r_data <= VOLT_ROM[i_addr];
        end else begin
            r_data <= '0;
        end
    end

    assign o_data = r_data;

endmodule

/* rtl/blg_div.sv */
module blg_div #(
    parameter int DIVISOR = blg_pkg::SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blg_pkg::t_div_req i_req,
    output blg_pkg::t_div_rsp o_rsp
);
    import blg_pkg::*;

    // floor(n / DIVISOR) for every n below 2**SUM_W as (n * RECIP) >> SHIFT,
    // RECIP rounded up so the error stays below one quotient step
    localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << SHIFT) + DIVISOR - 1) / DIVISOR);

    logic             r_busy;
    logic             r_done;
    logic [SUM_W-1:0] r_dvd;
    logic [SUM_W-1:0] r_quo;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_sh;

    assign prod    = PROD_W'(r_dvd) * PROD_W'(RECIP);
    assign prod_sh = prod >> SHIFT;

    // dividend registered on start, quotient registered on the next cycle while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
        end
        if (r_busy) begin
            r_quo <= prod_sh[SUM_W-1:0];
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* rtl/blg_ctrl.sv */
module blg_ctrl #(
    parameter int SAMPLES_PER_AVERAGE = blg_pkg::SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    blg_sample_if.sink                 i_sample,
    blg_result_if.source               o_result,
    input  logic [blg_pkg::HYST_W-1:0] i_hyst_mv,
    output blg_pkg::t_div_req          o_div_req,
    input  blg_pkg::t_div_rsp          i_div_rsp,
    output logic [blg_pkg::ADDR_W-1:0] o_rom_addr,
    input  logic [blg_pkg::MV_W-1:0]   i_rom_data
);
    import blg_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    t_state             r_state, n_state;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [MV_W-1:0]    r_last, n_last;
    logic [ADDR_W-1:0]  r_stable, n_stable;
    logic               r_known, n_known;
    logic [MV_W-1:0]    r_v, n_v;
    logic [ADDR_W-1:0]  r_hi, n_hi;
    logic [MV_W-1:0]    r_prev, n_prev;
    logic [ADDR_W-1:0]  r_lvl, n_lvl;
    logic [ADDR_W-1:0]  r_target, n_target;
    logic               r_out_vld, n_out_vld;
    logic [MV_W-1:0]    r_out_avg, n_out_avg;
    logic [LVL_W-1:0]   r_out_lvl, n_out_lvl;

    logic               accept;
    logic [SUM_W-1:0]   sum_acc;
    logic [MV_W-1:0]    avg;
    logic [MV_W-1:0]    diff;
    logic [MV_W-1:0]    span;
    logic [RND_W-1:0]   rnd_num;
    logic [RND_W-1:0]   rnd_lim;
    logic               round_up;
    logic [ADDR_W-1:0]  stable_cl;
    logic [MV_W:0]      up_lim;
    logic               up_ok;
    logic               dn_ok;
    logic               raw_vld;
    logic [ADDR_W-1:0]  raw_val;

    assign accept  = i_sample.valid && i_sample.ready;
    assign sum_acc = r_sum + SUM_W'(i_sample.sample_mv);
    assign avg     = i_div_rsp.quotient[MV_W-1:0];

    // round to nearest entry: frac >= 50 is the same as num >= 50 * span
    assign diff     = r_v - r_prev;
    assign span     = i_rom_data - r_prev;
    assign rnd_num  = RND_W'(diff) * ROUND_SCALE + RND_W'(span >> 1);
    assign rnd_lim  = RND_W'(span) * ROUND_HALF;
    assign round_up = (span != '0) && (rnd_num >= rnd_lim);

    assign stable_cl = (r_stable > TOP_LVL) ? TOP_LVL : r_stable;

    assign up_lim = {1'b0, i_rom_data} + (MV_W + 1)'(i_hyst_mv);
    assign up_ok  = {1'b0, r_v} >= up_lim;
    assign dn_ok  = ({1'b0, r_v} + (MV_W + 1)'(i_hyst_mv)) < {1'b0, i_rom_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_last    <= '0;
            r_stable  <= '0;
            r_known   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_last    <= n_last;
            r_stable  <= n_stable;
            r_known   <= n_known;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v       <= n_v;
        r_hi      <= n_hi;
        r_prev    <= n_prev;
        r_lvl     <= n_lvl;
        r_target  <= n_target;
        r_out_avg <= n_out_avg;
        r_out_lvl <= n_out_lvl;
    end

    always_comb begin
        n_state   = r_state;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_stable  = r_stable;
        n_known   = r_known;
        n_v       = r_v;
        n_hi      = r_hi;
        n_prev    = r_prev;
        n_lvl     = r_lvl;
        n_target  = r_target;
        n_out_vld = r_out_vld;
        n_out_avg = r_out_avg;
        n_out_lvl = r_out_lvl;
        o_div_req = '0;
        o_rom_addr = '0;
        raw_vld   = 1'b0;
        raw_val   = '0;

        if (r_out_vld && o_result.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_cnt == LAST_CNT) begin
                        o_div_req.start    = 1'b1;
                        o_div_req.dividend = sum_acc;
                        n_sum   = '0;
                        n_cnt   = '0;
                        n_state = ST_DIV;
                    end else begin
                        n_sum = sum_acc;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (i_div_rsp.done) begin
                    if (avg == r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_last = avg;
                        n_v    = avg;
                        if (avg <= ROM_LO_MV) begin
                            raw_vld = 1'b1;
                            raw_val = '0;
                        end else if (avg >= ROM_HI_MV) begin
                            raw_vld = 1'b1;
                            raw_val = TOP_LVL;
                        end else begin
                            n_hi       = ADDR_W'(1);
                            n_prev     = ROM_LO_MV;
                            o_rom_addr = ADDR_W'(1);
                            n_state    = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // rom data is the threshold at r_hi
                if (r_hi < TOP_LVL && i_rom_data <= r_v) begin
                    n_hi       = r_hi + 1'b1;
                    n_prev     = i_rom_data;
                    o_rom_addr = r_hi + 1'b1;
                end else begin
                    raw_vld = 1'b1;
                    raw_val = r_hi - 1'b1 + ADDR_W'(round_up);
                end
            end
            ST_WALK_UP: begin
                // rom data is the threshold at r_lvl + 1
                if (up_ok) begin
                    n_lvl = r_lvl + 1'b1;
                    if (r_lvl + 1'b1 < r_target) begin
                        o_rom_addr = r_lvl + ADDR_W'(2);
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_WALK_DN: begin
                // rom data is the threshold at r_lvl
                if (dn_ok) begin
                    n_lvl = r_lvl - 1'b1;
                    if (r_lvl - 1'b1 > r_target) begin
                        o_rom_addr = r_lvl - 1'b1;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_vld || o_result.ready) begin
                    n_out_vld = 1'b1;
                    n_out_avg = r_v;
                    n_out_lvl = LVL_W'(r_lvl);
                    n_stable  = r_lvl;
                    n_known   = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // raw level known: first result takes it, later ones walk toward it
        if (raw_vld) begin
            n_target = raw_val;
            if (!r_known) begin
                n_lvl   = raw_val;
                n_state = ST_FINISH;
            end else if (stable_cl < raw_val) begin
                n_lvl      = stable_cl;
                o_rom_addr = stable_cl + 1'b1;
                n_state    = ST_WALK_UP;
            end else if (stable_cl > raw_val) begin
                n_lvl      = stable_cl;
                o_rom_addr = stable_cl;
                n_state    = ST_WALK_DN;
            end else begin
                n_lvl   = stable_cl;
                n_state = ST_FINISH;
            end
        end
    end

    assign i_sample.ready      = (r_state == ST_IDLE);
    assign o_result.valid      = r_out_vld;
    assign o_result.average_mv = r_out_avg;
    assign o_result.level_pct  = r_out_lvl;

endmodule

/* tb/sv/battery_level_gauge_test.sv */
module battery_level_gauge_test;
    import blg_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int GROUP_LEN     = SAMPLES_DEF;
    localparam int MV_MAX        = (1 << MV_W) - 1;

    typedef struct {
        logic [MV_W-1:0]  average_mv;
        logic [LVL_W-1:0] level_pct;
    } t_gauge_reading;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [HYST_W-1:0] cfg_wr_data;

    blg_sample_if sample_if ();
    blg_result_if result_if ();

    battery_level_gauge u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_sample      (sample_if),
        .o_result      (result_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // gauge state as the block should hold it
    logic [SUM_W-1:0]  gauge_sum;
    int                gauge_count;
    logic [MV_W-1:0]   prev_average;
    logic [LVL_W-1:0]  held_level;
    bit                level_valid;
    logic [HYST_W-1:0] hyst_mv;

    t_gauge_reading pending_readings [$];
    int             error_count = 0;
    int             cycle_count = 0;
    bit             stall_en    = 1'b1;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // raw table position, rounded to the nearer neighbor
    function automatic int table_level(input int v);
        int hi;
        int lo_mv;
        int span;
        int frac;
        if (v <= int'(VOLT_ROM[0])) return 0;
        if (v >= int'(VOLT_ROM[TOP_IDX])) return TOP_IDX;
        hi = 1;
        while (hi < TOP_IDX && int'(VOLT_ROM[hi]) <= v) hi++;
        lo_mv = int'(VOLT_ROM[hi-1]);
        span  = int'(VOLT_ROM[hi]) - lo_mv;
        if (span <= 0) return hi - 1;
        frac = ((v - lo_mv) * 100 + span / 2) / span;
        return (frac >= 50) ? hi : hi - 1;
    endfunction

    // step the held level toward target while the margin allows
    function automatic int settle_level(input int v, input int target);
        int lvl;
        int h;
        if (!level_valid) return target;
        h   = int'(hyst_mv);
        lvl = int'(held_level);
        if (lvl > TOP_IDX) lvl = TOP_IDX;
        while (lvl < target && v >= int'(VOLT_ROM[lvl+1]) + h) lvl++;
        while (lvl > target && v < int'(VOLT_ROM[lvl]) - h) lvl--;
        return lvl;
    endfunction

    function automatic void absorb_sample(input logic [MV_W-1:0] mv);
        logic [MV_W-1:0] avg;
        int              target;
        gauge_sum = gauge_sum + SUM_W'(mv);
        gauge_count++;
        if (gauge_count < GROUP_LEN) return;
        avg         = MV_W'(gauge_sum / SUM_W'(GROUP_LEN));
        gauge_sum   = '0;
        gauge_count = 0;
        if (avg == prev_average) return;
        prev_average = avg;
        target       = table_level(int'(avg));
        held_level   = LVL_W'(settle_level(int'(avg), target));
        level_valid  = 1'b1;
        pending_readings.push_back('{average_mv: avg, level_pct: held_level});
    endfunction

    always @(posedge clk) begin : check_results
        t_gauge_reading want;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected result: average_mv %0d level_pct %0d",
                       result_if.average_mv, result_if.level_pct);
                error_count++;
            end else begin
                want = pending_readings.pop_front();
                if (result_if.average_mv !== want.average_mv) begin
                    $error("average_mv: expected %0d, got %0d",
                           want.average_mv, result_if.average_mv);
                    error_count++;
                end
                if (result_if.level_pct !== want.level_pct) begin
                    $error("level_pct: expected %0d, got %0d",
                           want.level_pct, result_if.level_pct);
                    error_count++;
                end
            end
        end
    end

    // result backpressure in bursts
    always begin
        @(negedge clk);
        if (stall_en && $urandom_range(0, 3) == 0) begin
            result_if.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        result_if.ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
    end

    // called and returns at a falling edge
    task automatic send_sample(input logic [MV_W-1:0] mv);
        if (stall_en && $urandom_range(0, 3) == 0) begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        sample_if.valid     <= 1'b1;
        sample_if.sample_mv <= mv;
        do @(posedge clk); while (sample_if.ready !== 1'b1);
        absorb_sample(mv);
        @(negedge clk);
    endtask

    task automatic send_pair_group(input int mv_a, input int mv_b);
        for (int i = 0; i < GROUP_LEN; i++) begin
            send_sample(MV_W'(i[0] ? mv_b : mv_a));
        end
    endtask

    task automatic send_spread_group(input int center, input int spread);
        int mv;
        for (int i = 0; i < GROUP_LEN; i++) begin
            mv = center + int'($urandom_range(0, 2 * spread)) - spread;
            if (mv < 0) mv = 0;
            if (mv > MV_MAX) mv = MV_MAX;
            send_sample(MV_W'(mv));
        end
    endtask

    // hold off until every expected transaction is back and the block is idle
    task automatic wait_until_settled();
        sample_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_hysteresis(input logic [HYST_W-1:0] value);
        wait_until_settled();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        hyst_mv = value;
    endtask

    // an all-zero group matches the cleared average: nothing comes out
    task automatic test_zero_average_after_reset();
        send_pair_group(0, 0);
    endtask

    // midway between the first two entries rounds up; no walk on the first level
    task automatic test_first_level_direct();
        send_pair_group(int'(VOLT_ROM[0]), int'(VOLT_ROM[1]));
    endtask

    task automatic test_full_scale_samples();
        send_pair_group(MV_MAX, MV_MAX);
    endtask

    // average lands exactly on the lowest entry, walk goes all the way down
    task automatic test_bottom_of_table();
        send_pair_group(0, 2 * int'(VOLT_ROM[0]));
        wait_until_settled();
    endtask

    task automatic test_walk(input logic [HYST_W-1:0] hyst, input int groups);
        int center;
        int h;
        set_hysteresis(hyst);
        h      = int'(hyst);
        center = 3700;
        repeat (groups) begin
            case ($urandom_range(0, 15))
                0: begin
                    // raw noise, also shifts the group alignment
                    repeat ($urandom_range(1, 12)) send_sample(MV_W'($urandom));
                end
                1: send_pair_group(int'(prev_average), int'(prev_average));
                2, 3, 4, 5: begin
                    center = int'(VOLT_ROM[$urandom_range(0, TOP_IDX)]);
                    case ($urandom_range(0, 4))
                        0: center = center - h - 1;
                        1: center = center - h;
                        2: center = center;
                        3: center = center + h - 1;
                        default: center = center + h;
                    endcase
                    if (center < 0) center = 0;
                    send_spread_group(center, 0);
                end
                6: begin
                    center = $urandom_range(3000, 4400);
                    send_spread_group(center, $urandom_range(0, 200));
                end
                default: begin
                    center = center + int'($urandom_range(0, 120)) - 60;
                    if (center < 3000) center = 3000;
                    if (center > 4400) center = 4400;
                    send_spread_group(center, $urandom_range(0, 40));
                end
            endcase
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        sample_if.valid     = 1'b0;
        sample_if.sample_mv = '0;
        result_if.ready     = 1'b0;
        gauge_sum           = '0;
        gauge_count         = 0;
        prev_average        = '0;
        held_level          = '0;
        level_valid         = 1'b0;
        hyst_mv             = HYST_RESET;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_zero_average_after_reset();
        test_first_level_direct();
        test_full_scale_samples();
        test_bottom_of_table();

        test_walk(8'd0, 26);
        test_walk(8'd255, 26);
        test_walk(8'd1, 26);
        test_walk(HYST_W'($urandom_range(2, 254)), 26);
        test_walk(HYST_W'($urandom_range(2, 60)), 26);
        stall_en = 1'b0;
        test_walk(8'd10, 26);

        wait_until_settled();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
